// ===== src/midi_track_event_parser_assert.svh =====
// Assertion helpers for the track event parser. Each expects clk and arst_n
// in scope and is disabled while reset is held.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Same-cycle implication
`define MTEP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mtep_pkg.sv =====
package mtep_pkg;

	// Parser phase within one event
	typedef enum logic [2:0] {
		PH_DELTA_FIRST = 3'd0,
		PH_DELTA_MORE  = 3'd1,
		PH_STATUS      = 3'd2,
		PH_DATA_ONE    = 3'd3,
		PH_DATA_TWO    = 3'd4,
		PH_META_KIND   = 3'd5,
		PH_LENGTH      = 3'd6,
		PH_PAYLOAD     = 3'd7
	} phase_t;

	// Result kinds, carried on tuser
	typedef enum logic [2:0] {
		KIND_CHANNEL   = 3'd0,
		KIND_META_HDR  = 3'd1,
		KIND_SYSEX_HDR = 3'd2,
		KIND_PAYLOAD   = 3'd3,
		KIND_BAD       = 3'd4,
		KIND_TRUNC     = 3'd5
	} kind_t;

	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam logic [7:0] STATUS_META  = 8'hFF;
	localparam logic [3:0] TYPE_PROGRAM = 4'hC;
	localparam logic [3:0] TYPE_PRESSURE = 4'hD;
	localparam logic [3:0] TYPE_SYSTEM  = 4'hF;

	localparam int unsigned TDATA_W = 112;

	// Parser state carried between bytes
	typedef struct packed {
		phase_t      phase;
		logic [31:0] acc;
		logic [31:0] delta;
		logic [7:0]  status;
		logic [7:0]  first_data;
		logic [7:0]  meta_kind;
		logic [31:0] remaining;
		logic        stopped;
	} parse_state_t;

	// One result transaction
	typedef struct packed {
		kind_t       kind;
		logic [31:0] delta_ticks;
		logic [7:0]  status_byte;
		logic [3:0]  channel;
		logic [7:0]  data_one;
		logic [7:0]  data_two;
		logic [7:0]  meta_kind;
		logic [31:0] payload_length;
		logic [7:0]  payload_value;
		logic        payload_last;
	} result_t;

endpackage

// ===== src/mtep_decode.sv =====
// Per-byte decode: next parser state and the result this byte produces.
module mtep_decode (
	input  mtep_pkg::parse_state_t st,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	output mtep_pkg::parse_state_t nxt,
	output mtep_pkg::result_t      res,
	output logic                   res_valid
);

	logic [31:0]           acc_shift;
	logic                  bad;
	mtep_pkg::phase_t      ph_step;
	mtep_pkg::parse_state_t stp;
	logic                  one_data;
	logic                  is_meta;
	logic                  is_channel;

	// Variable-length number step: shift in seven bits, keep the low 32
	assign acc_shift  = {st.acc[24:0], data_byte[6:0]};
	assign one_data   = (st.status[7:4] == mtep_pkg::TYPE_PROGRAM) ||
	                    (st.status[7:4] == mtep_pkg::TYPE_PRESSURE);
	assign is_meta    = (st.status == mtep_pkg::STATUS_META);
	assign is_channel = data_byte[7] && (data_byte[7:4] != mtep_pkg::TYPE_SYSTEM);

	// Next state, before end-of-track handling
	always_comb begin
		stp = st;
		bad = 1'b0;
		unique case (st.phase)
			mtep_pkg::PH_DELTA_FIRST, mtep_pkg::PH_DELTA_MORE: begin
				stp.acc = acc_shift;
				if (data_byte[7]) begin
					stp.phase = mtep_pkg::PH_DELTA_MORE;
				end else begin
					stp.delta = acc_shift;
					stp.acc   = '0;
					stp.phase = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				if (data_byte == mtep_pkg::STATUS_SYSEX) begin
					stp.status    = data_byte;
					stp.meta_kind = '0;
					stp.acc       = '0;
					stp.phase     = mtep_pkg::PH_LENGTH;
				end else if (data_byte == mtep_pkg::STATUS_META) begin
					stp.status = data_byte;
					stp.phase  = mtep_pkg::PH_META_KIND;
				end else if (is_channel) begin
					stp.status = data_byte;
					stp.phase  = mtep_pkg::PH_DATA_ONE;
				end else begin
					bad       = 1'b1;
					stp.phase = mtep_pkg::PH_DELTA_FIRST;
				end
			end
			mtep_pkg::PH_DATA_ONE: begin
				stp.first_data = data_byte;
				stp.phase = one_data ? mtep_pkg::PH_DELTA_FIRST : mtep_pkg::PH_DATA_TWO;
			end
			mtep_pkg::PH_DATA_TWO: begin
				stp.phase = mtep_pkg::PH_DELTA_FIRST;
			end
			mtep_pkg::PH_META_KIND: begin
				stp.meta_kind = data_byte;
				stp.acc       = '0;
				stp.phase     = mtep_pkg::PH_LENGTH;
			end
			mtep_pkg::PH_LENGTH: begin
				stp.acc = acc_shift;
				if (!data_byte[7]) begin
					stp.remaining = acc_shift;
					stp.acc       = '0;
					stp.phase     = (acc_shift == '0) ? mtep_pkg::PH_DELTA_FIRST
					                                  : mtep_pkg::PH_PAYLOAD;
				end
			end
			mtep_pkg::PH_PAYLOAD: begin
				if (st.remaining != '0) begin
					stp.remaining = st.remaining - 32'd1;
				end
				if (st.remaining[31:1] == '0) begin
					stp.phase = mtep_pkg::PH_DELTA_FIRST;
				end
			end
			default: begin
				stp.phase = mtep_pkg::PH_DELTA_FIRST;
			end
		endcase
		ph_step = stp.phase;
	end

	// Stopped track, bad status and end-of-track handling
	always_comb begin
		nxt = stp;
		if (st.stopped) begin
			nxt = st;
		end
		if (bad && !last_byte && !st.stopped) begin
			nxt.stopped = 1'b1;
		end
		if (last_byte) begin
			nxt.phase     = mtep_pkg::PH_DELTA_FIRST;
			nxt.acc       = '0;
			nxt.remaining = '0;
			nxt.stopped   = 1'b0;
		end
	end

	// Result for this byte
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (!st.stopped) begin
			unique case (st.phase)
				mtep_pkg::PH_STATUS: begin
					if (bad) begin
						res.kind        = mtep_pkg::KIND_BAD;
						res.delta_ticks = st.delta;
						res.status_byte = data_byte;
						res_valid       = 1'b1;
					end
				end
				mtep_pkg::PH_DATA_ONE: begin
					if (one_data) begin
						res.kind        = mtep_pkg::KIND_CHANNEL;
						res.delta_ticks = st.delta;
						res.status_byte = st.status;
						res.channel     = st.status[3:0];
						res.data_one    = data_byte;
						res_valid       = 1'b1;
					end
				end
				mtep_pkg::PH_DATA_TWO: begin
					res.kind        = mtep_pkg::KIND_CHANNEL;
					res.delta_ticks = st.delta;
					res.status_byte = st.status;
					res.channel     = st.status[3:0];
					res.data_one    = st.first_data;
					res.data_two    = data_byte;
					res_valid       = 1'b1;
				end
				mtep_pkg::PH_LENGTH: begin
					if (!data_byte[7]) begin
						res.kind           = is_meta ? mtep_pkg::KIND_META_HDR
						                             : mtep_pkg::KIND_SYSEX_HDR;
						res.delta_ticks    = st.delta;
						res.status_byte    = st.status;
						res.meta_kind      = is_meta ? st.meta_kind : 8'd0;
						res.payload_length = acc_shift;
						res.payload_last   = (acc_shift == '0);
						res_valid          = 1'b1;
					end
				end
				mtep_pkg::PH_PAYLOAD: begin
					res.kind          = mtep_pkg::KIND_PAYLOAD;
					res.delta_ticks   = st.delta;
					res.status_byte   = st.status;
					res.meta_kind     = is_meta ? st.meta_kind : 8'd0;
					res.payload_value = data_byte;
					res.payload_last  = (st.remaining[31:1] == '0);
					res_valid         = 1'b1;
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
			// Event left open at the last byte replaces any other result
			if (last_byte && !bad && (ph_step != mtep_pkg::PH_DELTA_FIRST)) begin
				res       = '0;
				res.kind  = mtep_pkg::KIND_TRUNC;
				res_valid = 1'b1;
			end
		end
	end

endmodule

// ===== src/mtep_out_stage.sv =====
// Result register; advances whenever it is empty or being drained.
module mtep_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mtep_pkg::result_t res_in,
	input  logic              ready,
	output logic              advance,
	output logic              valid,
	output mtep_pkg::result_t res_out
);

	logic              valid_q;
	mtep_pkg::result_t res_q;

	assign advance = !valid_q || ready;
	assign valid   = valid_q;
	assign res_out = res_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== src/midi_track_event_parser.sv =====
// Track event parser for the body of one MIDI file track chunk. Bytes enter
// on s_axis, one per transaction, tlast on the final byte of the track; a
// new byte is taken every cycle while the result side keeps up. Each byte
// passes an input register, one step of decode against the parser state,
// and a result register, so a result is presented on the cycle after its
// closing byte is decoded. Results leave on m_axis with the kind on tuser and the
// last-payload mark on tlast: channel events, sysex/meta headers with their
// length, one transaction per payload byte, bad status (after which the rest
// of the track is dropped) and truncated when a track ends mid-event.
module midi_track_event_parser (
	input  logic         clk,
	input  logic         arst_n,
	// Input bytes
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	// Results
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [mtep_pkg::TDATA_W-1:0] m_axis_tdata, // [31:0] delta_ticks,
	                                     // [39:32] status_byte,
	                                     // [43:40] channel, [51:44] data_one,
	                                     // [59:52] data_two, [67:60] meta_kind,
	                                     // [99:68] payload_length,
	                                     // [107:100] payload_value, [111:108] zero
	output logic         m_axis_tlast,   // payload_last
	output logic [2:0]   m_axis_tuser    // [2:0] item_kind
);

	logic                   byte_valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   advance;
	logic                   fire;
	mtep_pkg::parse_state_t state_q;
	mtep_pkg::parse_state_t state_nxt;
	mtep_pkg::result_t      res;
	logic                   res_valid;
	mtep_pkg::result_t      res_out;

	assign s_axis_tready = !byte_valid_s1 || advance;
	assign fire          = byte_valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			byte_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: mtep_pkg::PH_DELTA_FIRST, default: '0};
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	mtep_decode u_decode (
		.st        (state_q),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.res       (res),
		.res_valid (res_valid)
	);

	mtep_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire && res_valid),
		.res_in  (res),
		.ready   (m_axis_tready),
		.advance (advance),
		.valid   (m_axis_tvalid),
		.res_out (res_out)
	);

	// Result packing
	assign m_axis_tdata = {4'd0, res_out.payload_value, res_out.payload_length,
	                       res_out.meta_kind, res_out.data_two, res_out.data_one,
	                       res_out.channel, res_out.status_byte, res_out.delta_ticks};
	assign m_axis_tlast = res_out.payload_last;
	assign m_axis_tuser = res_out.kind;

`include "midi_track_event_parser_assert.svh"

	`MTEP_ASSERT_NOW(a_trunc_empty,
		m_axis_tvalid && (m_axis_tuser == mtep_pkg::KIND_TRUNC),
		(m_axis_tdata == '0) && !m_axis_tlast,
		"truncated result carries data")
	`MTEP_ASSERT_NOW(a_payload_status,
		m_axis_tvalid && (m_axis_tuser == mtep_pkg::KIND_PAYLOAD),
		(m_axis_tdata[39:32] == mtep_pkg::STATUS_SYSEX) ||
		(m_axis_tdata[39:32] == mtep_pkg::STATUS_META),
		"payload without sysex or meta status")
	`MTEP_ASSERT_NOW(a_stopped_silent, state_q.stopped, !res_valid,
		"result produced while track is stopped")
	`MTEP_ASSERT_NOW(a_ready_stall, !s_axis_tready,
		byte_valid_s1 && m_axis_tvalid && !m_axis_tready,
		"input stalled without output backpressure")
	`MTEP_ASSERT_NEXT(a_fire_loads, fire && res_valid, m_axis_tvalid,
		"decoded result not presented")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int RUN_LIMIT   = 400000;
	localparam int TRACK_BYTES = 1600;
	localparam int PHASE_BYTES = 200;

	// Expected-result tracker: mirrors the parser state byte by byte
	class event_scoreboard;
		mtep_pkg::phase_t  phase;
		logic [31:0]       acc;
		logic [31:0]       delta;
		logic [31:0]       remaining;
		logic [7:0]        status;
		logic [7:0]        first_data;
		logic [7:0]        meta_kind;
		bit                stopped;
		mtep_pkg::result_t pending[$];
		int                errors;
		int                taken;

		function new();
			phase      = mtep_pkg::PH_DELTA_FIRST;
			acc        = '0;
			delta      = '0;
			remaining  = '0;
			status     = '0;
			first_data = '0;
			meta_kind  = '0;
			stopped    = 1'b0;
			errors     = 0;
			taken      = 0;
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
			if (got !== want)
				report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		// Accepted input byte: advance the parser and queue any result it causes
		function void note_byte(input logic [7:0] b, input bit last);
			mtep_pkg::result_t r;
			bit                hit;
			bit                bad;
			bit                chan;
			logic [7:0]        d1;
			logic [7:0]        d2;

			r    = '0;
			hit  = 1'b0;
			bad  = 1'b0;
			chan = 1'b0;
			d1   = '0;
			d2   = '0;

			// after a bad status, everything up to the end of the track is dropped
			if (stopped) begin
				if (last) begin
					stopped   = 1'b0;
					phase     = mtep_pkg::PH_DELTA_FIRST;
					acc       = '0;
					remaining = '0;
				end
				return;
			end
			taken++;

			case (phase)
				mtep_pkg::PH_DELTA_FIRST, mtep_pkg::PH_DELTA_MORE: begin
					acc = (acc << 7) + b[6:0];
					if (b[7]) begin
						phase = mtep_pkg::PH_DELTA_MORE;
					end else begin
						delta = acc;
						acc   = '0;
						phase = mtep_pkg::PH_STATUS;
					end
				end
				mtep_pkg::PH_STATUS: begin
					if (b == mtep_pkg::STATUS_SYSEX) begin
						status    = b;
						meta_kind = '0;
						acc       = '0;
						phase     = mtep_pkg::PH_LENGTH;
					end else if (b == mtep_pkg::STATUS_META) begin
						status = b;
						phase  = mtep_pkg::PH_META_KIND;
					end else if (b >= 8'h80 && b <= 8'hEF) begin
						status = b;
						phase  = mtep_pkg::PH_DATA_ONE;
					end else begin
						r.kind        = mtep_pkg::KIND_BAD;
						r.delta_ticks = delta;
						r.status_byte = b;
						hit           = 1'b1;
						bad           = 1'b1;
						phase         = mtep_pkg::PH_DELTA_FIRST;
					end
				end
				mtep_pkg::PH_DATA_ONE: begin
					first_data = b;
					// program change and channel pressure carry one data byte
					if (status[7:4] == mtep_pkg::TYPE_PROGRAM ||
					    status[7:4] == mtep_pkg::TYPE_PRESSURE) begin
						chan  = 1'b1;
						d1    = b;
						phase = mtep_pkg::PH_DELTA_FIRST;
					end else begin
						phase = mtep_pkg::PH_DATA_TWO;
					end
				end
				mtep_pkg::PH_DATA_TWO: begin
					chan  = 1'b1;
					d1    = first_data;
					d2    = b;
					phase = mtep_pkg::PH_DELTA_FIRST;
				end
				mtep_pkg::PH_META_KIND: begin
					meta_kind = b;
					acc       = '0;
					phase     = mtep_pkg::PH_LENGTH;
				end
				mtep_pkg::PH_LENGTH: begin
					acc = (acc << 7) + b[6:0];
					if (!b[7]) begin
						remaining        = acc;
						acc              = '0;
						r.kind           = (status == mtep_pkg::STATUS_META)
							? mtep_pkg::KIND_META_HDR : mtep_pkg::KIND_SYSEX_HDR;
						r.delta_ticks    = delta;
						r.status_byte    = status;
						r.meta_kind      = (status == mtep_pkg::STATUS_META) ? meta_kind : 8'h00;
						r.payload_length = remaining;
						r.payload_last   = (remaining == 0);
						hit              = 1'b1;
						phase            = (remaining == 0) ? mtep_pkg::PH_DELTA_FIRST
							: mtep_pkg::PH_PAYLOAD;
					end
				end
				default: begin
					r.kind          = mtep_pkg::KIND_PAYLOAD;
					r.delta_ticks   = delta;
					r.status_byte   = status;
					r.meta_kind     = (status == mtep_pkg::STATUS_META) ? meta_kind : 8'h00;
					r.payload_value = b;
					r.payload_last  = (remaining <= 1);
					hit             = 1'b1;
					if (remaining > 0)
						remaining--;
					if (remaining == 0)
						phase = mtep_pkg::PH_DELTA_FIRST;
				end
			endcase

			if (chan) begin
				r.kind        = mtep_pkg::KIND_CHANNEL;
				r.delta_ticks = delta;
				r.status_byte = status;
				r.channel     = status[3:0];
				r.data_one    = d1;
				r.data_two    = d2;
				hit           = 1'b1;
			end

			if (bad && !last)
				stopped = 1'b1;

			// end of track: an unfinished event turns into a truncated result
			if (last) begin
				if (!bad && phase != mtep_pkg::PH_DELTA_FIRST) begin
					r      = '0;
					r.kind = mtep_pkg::KIND_TRUNC;
					hit    = 1'b1;
				end
				phase     = mtep_pkg::PH_DELTA_FIRST;
				acc       = '0;
				remaining = '0;
				stopped   = 1'b0;
			end

			if (hit)
				pending.insert(pending.size(), r);
		endfunction

		// Result transaction: compare with the oldest expected result
		task check_result(input mtep_pkg::result_t got);
			mtep_pkg::result_t want;

			if (pending.size() == 0) begin
				report($sformatf("unexpected result, kind %0d", got.kind));
				return;
			end
			want = pending.pop_front();
			check_field("item_kind", got.kind, want.kind);
			check_field("delta_ticks", got.delta_ticks, want.delta_ticks);
			check_field("status_byte", got.status_byte, want.status_byte);
			check_field("channel", got.channel, want.channel);
			check_field("data_one", got.data_one, want.data_one);
			check_field("data_two", got.data_two, want.data_two);
			check_field("meta_kind", got.meta_kind, want.meta_kind);
			check_field("payload_length", got.payload_length, want.payload_length);
			check_field("payload_value", got.payload_value, want.payload_value);
			check_field("payload_last", got.payload_last, want.payload_last);
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic [2:0]   m_axis_tuser;

	event_scoreboard sb = new();
	// 0 no idling, 1 sender idle, 2 receiver stalls, 3 both
	int              mode = 0;
	logic [7:0]      trk[$];

	midi_track_event_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: check each transaction, then pick the next ready
	always @(posedge clk) begin : result_monitor
		mtep_pkg::result_t got;

		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind           = mtep_pkg::kind_t'(m_axis_tuser);
			got.delta_ticks    = m_axis_tdata[31:0];
			got.status_byte    = m_axis_tdata[39:32];
			got.channel        = m_axis_tdata[43:40];
			got.data_one       = m_axis_tdata[51:44];
			got.data_two       = m_axis_tdata[59:52];
			got.meta_kind      = m_axis_tdata[67:60];
			got.payload_length = m_axis_tdata[99:68];
			got.payload_value  = m_axis_tdata[107:100];
			got.payload_last   = m_axis_tlast;
			sb.check_result(got);
		end
		case (mode)
			2:       m_axis_tready <= ($urandom_range(0, 99) >= 52);
			3:       m_axis_tready <= ($urandom_range(0, 99) >= 24);
			default: m_axis_tready <= 1'b1;
		endcase
	end

	// Run limit
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	// One byte transaction, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input bit last);
		int pct;

		pct = (mode == 1) ? 52 : (mode == 3) ? 24 : 0;
		while ($urandom_range(0, 99) < pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_byte(b, last);
	endtask

	// Whole track from trk, tlast on its final byte
	task automatic send_track();
		int i;

		for (i = 0; i < trk.size(); i++)
			send_byte(trk[i], i == trk.size() - 1);
		trk.delete();
	endtask

	// Append one byte to the track under construction
	task automatic append_byte(input logic [7:0] v);
		trk.insert(trk.size(), v);
	endtask

	// Variable-length number, sometimes with redundant or overflowing lead bytes
	task automatic push_number(input logic [31:0] v, input bit garbage_ok);
		int n;
		int pads;
		int i;

		n = 1;
		while (n < 5 && (v >> (7 * n)) != 0)
			n++;
		pads = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
		repeat (pads) begin
			if (garbage_ok && $urandom_range(0, 2) == 0)
				append_byte(8'h80 | 8'($urandom_range(0, 127)));
			else
				append_byte(8'h80);
		end
		for (i = n - 1; i >= 0; i--)
			append_byte({i != 0, 7'(v >> (7 * i))});
	endtask

	function automatic logic [31:0] pick_number();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, 127);
			5, 6:          return $urandom_range(128, 16383);
			7:             return $urandom;
			8:             return 32'h0;
			default:       return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Random track: mostly well-formed events, some noise, bad status and cut-off ends
	task automatic build_track();
		int          nev;
		int          e;
		int          sel;
		int          mark;
		logic [3:0]  ty;
		logic [31:0] plen;
		bit          ended;

		trk.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 16)) append_byte(8'($urandom));
			return;
		end
		nev   = $urandom_range(1, 8);
		ended = 1'b0;
		mark  = 0;
		for (e = 0; e < nev && !ended; e++) begin
			mark = trk.size();
			push_number(pick_number(), 1'b1);
			sel = $urandom_range(0, 19);
			if (sel < 12) begin
				ty = 4'($urandom_range(8, 14));
				append_byte({ty, 4'($urandom)});
				append_byte(($urandom_range(0, 7) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 127)));
				if (ty != mtep_pkg::TYPE_PROGRAM && ty != mtep_pkg::TYPE_PRESSURE)
					append_byte(($urandom_range(0, 7) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, 127)));
			end else if (sel < 18) begin
				append_byte((sel < 15) ? mtep_pkg::STATUS_META : mtep_pkg::STATUS_SYSEX);
				if (sel < 15)
					append_byte(8'($urandom));
				plen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				push_number(plen, 1'b0);
				repeat (plen) append_byte(8'($urandom));
			end else if (sel == 18) begin
				// unknown status: data byte or undefined system byte
				append_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
					: 8'($urandom_range(241, 254)));
				repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
				ended = 1'b1;
			end else begin
				// huge payload, cut short by the end of the track
				if ($urandom_range(0, 1)) begin
					append_byte(mtep_pkg::STATUS_META);
					append_byte(8'($urandom));
				end else begin
					append_byte(mtep_pkg::STATUS_SYSEX);
				end
				plen = $urandom | 32'h100;
				push_number(plen, 1'b0);
				repeat ($urandom_range(0, 6)) append_byte(8'($urandom));
				ended = 1'b1;
			end
		end
		// sometimes cut the final event short
		if (!ended && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, trk.size() - mark - 1)) trk.pop_back();
	endtask

	initial begin : stimulus
		int next_switch;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// note on with top-range data, overflowing delta then program change with
		// top bit set in data, empty meta, short sysex, bad status with ignored tail
		trk = '{8'h00, 8'h90, 8'h00, 8'h7F,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hCF, 8'hFF,
			8'h00, 8'hFF, 8'h2F, 8'h00,
			8'h00, 8'hF0, 8'h02, 8'hAA, 8'h55,
			8'h00, 8'h00, 8'h12, 8'h34};
		send_track();
		// pitch bend cut off by the end of the track
		trk = '{8'h00, 8'hEF, 8'h01};
		send_track();

		next_switch = PHASE_BYTES;
		while (sb.taken < TRACK_BYTES) begin
			if (sb.taken >= next_switch) begin
				// hold off until every result is out, then change idling
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (sb.pending.size() != 0);
				mode        = (mode + 1) % 4;
				next_switch = next_switch + PHASE_BYTES;
			end
			build_track();
			send_track();
		end
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
